// ===== rtl/was_pkg.sv =====
`timescale 1ns / 1ps

package was_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;

  localparam int unsigned VALUE_W   = 17;
  localparam int unsigned DEPTH_FW  = 9;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned QW_MEAN   = 17;
  localparam int unsigned QW_WEIGHT = 32;

  localparam logic [VALUE_W-1:0] FULL_SCALE  = 17'd65536;
  localparam logic [VALUE_W-1:0] SMALL_LIMIT = 17'd66;

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_TRUNC = 1'b1
  } cmd_e;

  // Truncated Q0.60 series for e^-0.1 and e^-0.01; later terms are all zero
  localparam logic [63:0] Q_ONE = 64'h1 << 60;

  localparam logic [63:0] E10_T1  = Q_ONE   / 64'd10;
  localparam logic [63:0] E10_T2  = E10_T1  / 64'd20;
  localparam logic [63:0] E10_T3  = E10_T2  / 64'd30;
  localparam logic [63:0] E10_T4  = E10_T3  / 64'd40;
  localparam logic [63:0] E10_T5  = E10_T4  / 64'd50;
  localparam logic [63:0] E10_T6  = E10_T5  / 64'd60;
  localparam logic [63:0] E10_T7  = E10_T6  / 64'd70;
  localparam logic [63:0] E10_T8  = E10_T7  / 64'd80;
  localparam logic [63:0] E10_T9  = E10_T8  / 64'd90;
  localparam logic [63:0] E10_T10 = E10_T9  / 64'd100;
  localparam logic [63:0] E10_T11 = E10_T10 / 64'd110;
  localparam logic [63:0] E10_T12 = E10_T11 / 64'd120;
  localparam logic [63:0] EXP_M10 = Q_ONE - E10_T1 + E10_T2 - E10_T3 + E10_T4 - E10_T5
                                  + E10_T6 - E10_T7 + E10_T8 - E10_T9 + E10_T10
                                  - E10_T11 + E10_T12;

  localparam logic [63:0] E100_T1 = Q_ONE   / 64'd100;
  localparam logic [63:0] E100_T2 = E100_T1 / 64'd200;
  localparam logic [63:0] E100_T3 = E100_T2 / 64'd300;
  localparam logic [63:0] E100_T4 = E100_T3 / 64'd400;
  localparam logic [63:0] E100_T5 = E100_T4 / 64'd500;
  localparam logic [63:0] E100_T6 = E100_T5 / 64'd600;
  localparam logic [63:0] E100_T7 = E100_T6 / 64'd700;
  localparam logic [63:0] E100_T8 = E100_T7 / 64'd800;
  localparam logic [63:0] E100_T9 = E100_T8 / 64'd900;
  localparam logic [63:0] EXP_M100 = Q_ONE - E100_T1 + E100_T2 - E100_T3 + E100_T4
                                   - E100_T5 + E100_T6 - E100_T7 + E100_T8 - E100_T9;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/was_if.sv =====
`timescale 1ns / 1ps

interface was_in_if
  import was_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                command;
  logic [VALUE_W-1:0]  value;
  logic [DEPTH_FW-1:0] new_depth;

  modport source (output valid, command, value, new_depth, input ready);
  modport sink   (input valid, command, value, new_depth, output ready);
endinterface

interface was_out_if
  import was_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DEPTH_FW-1:0] depth;
  logic [VALUE_W-1:0]  accuracy;
  logic                error;

  modport source (output valid, depth, accuracy, error, input ready);
  modport sink   (input valid, depth, accuracy, error, output ready);
endinterface

// ===== rtl/was_div.sv =====
`timescale 1ns / 1ps

module was_div
  import was_pkg::*;
#(
  parameter int unsigned DVW = 64,
  parameter int unsigned DSW = 41
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [DVW-1:0]       dividend_i,
  input  logic [DSW-1:0]       divisor_i,
  output div_stat_t            stat_o,
  output logic [QW_WEIGHT-1:0] quo_o
);

  logic [5:0]           cnt_q;
  logic [DSW-1:0]       rem_q;
  logic [DSW-1:0]       dsr_q;
  logic [QW_WEIGHT-1:0] dvd_q;
  logic [QW_WEIGHT-1:0] quo_q;
  logic                 done_q;

  logic [DVW-1:0]       hi_init;
  logic [QW_WEIGHT-1:0] lo_init;
  logic [DSW:0]         shifted;
  logic [DSW:0]         diff;
  logic                 ge;

  // Upper part is below the divisor, so it seeds the remainder directly
  assign hi_init = req_i.wide ? (dividend_i >> QW_WEIGHT) : (dividend_i >> QW_MEAN);
  assign lo_init = req_i.wide ? dividend_i[QW_WEIGHT-1:0]
                              : {dividend_i[QW_MEAN-1:0], {(QW_WEIGHT-QW_MEAN){1'b0}}};

  assign shifted = {rem_q, dvd_q[QW_WEIGHT-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= req_i.wide ? 6'(QW_WEIGHT) : 6'(QW_MEAN);
        rem_q <= hi_init[DSW-1:0];
        dsr_q <= divisor_i;
        dvd_q <= lo_init;
        quo_q <= '0;
      end else if (cnt_q != '0) begin
        rem_q  <= ge ? diff[DSW-1:0] : shifted[DSW-1:0];
        dvd_q  <= {dvd_q[QW_WEIGHT-2:0], 1'b0};
        quo_q  <= {quo_q[QW_WEIGHT-2:0], ge};
        cnt_q  <= cnt_q - 6'd1;
        done_q <= cnt_q == 6'd1;
      end
    end
  end

  assign stat_o.busy = cnt_q != '0;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

endmodule

// ===== rtl/weighted_accuracy_stack_unit.sv =====
`timescale 1ns / 1ps
// Items are handled one at a time: a push or truncate runs through the 17-step mean
// divide unless the resulting stack is empty; the next item is taken while a result
// waits, and a result is held until the output register is free.
// Reset: stack empties at once, then a weight table build runs over all STACK_DEPTH
// entries before the first item is taken.

module weighted_accuracy_stack_unit
  import was_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  was_in_if.sink        in_i,
  was_out_if.source     out_o
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned DW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW    = (DW > DEPTH_FW) ? DW : DEPTH_FW;
  localparam int unsigned FW    = WEIGHT_W + AW;
  localparam int unsigned GW    = FW + VALUE_W;
  localparam int unsigned DVW   = (GW + 2 > 64) ? GW + 2 : 64;
  localparam int unsigned DSW   = FW + 1;
  localparam int unsigned ACC_W = 120;
  localparam int unsigned PW    = VALUE_W + WEIGHT_W;

  typedef enum logic [3:0] {
    ST_BDIV,
    ST_BWAIT,
    ST_BMUL,
    ST_BNEXT,
    ST_IDLE,
    ST_LOAD,
    ST_SUM,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [DW-1:0]       depth_q;
  logic [AW-1:0]       bidx_q;
  logic [59:0]         q_q;
  logic [ACC_W-1:0]    acc_q;
  logic [2:0]          mcnt_q;
  logic [VALUE_W-1:0]  a_q;
  logic                push_ok_q;
  logic                err_q;
  logic                empty_q;
  logic                prev_zero_q;
  logic [AW-1:0]       widx_q;
  logic [WEIGHT_W-1:0] w_rd_q;
  logic [FW-1:0]       fp_rd_q;
  logic [GW-1:0]       gp_rd_q;
  logic [FW-1:0]       f_q;
  logic [GW-1:0]       g_q;
  logic [VALUE_W-1:0]  res_q;
  logic [63:0]         prod_q;
  logic                out_valid_q;
  logic [DEPTH_FW-1:0] out_depth_q;
  logic [VALUE_W-1:0]  out_acc_q;
  logic                out_err_q;

  logic [WEIGHT_W-1:0] wmem [STACK_DEPTH];
  logic [FW-1:0]       fmem [STACK_DEPTH];
  logic [GW-1:0]       gmem [STACK_DEPTH];

  logic                in_fire;
  logic                out_fire;
  logic                is_push;
  logic                full;
  logic                trunc_bad;
  logic                push_ok;
  logic                item_err;
  logic [VALUE_W-1:0]  val_sat;
  logic [VALUE_W-1:0]  val_eff;
  logic [DW-1:0]       tgt;
  logic [DW-1:0]       rd_depth;
  logic [DW-1:0]       raddr_full;
  logic [AW-1:0]       raddr;
  logic [CW-1:0]       depth_ext;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [ACC_W-1:0]    part;
  logic [2:0]          pidx;
  logic [FW-1:0]       f_sum;
  logic [GW-1:0]       g_sum;
  logic [VALUE_W-1:0]  mean_clamp;
  logic [VALUE_W-1:0]  mean_res;
  logic                out_free;

  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [DVW-1:0]      div_dividend;
  logic [DSW-1:0]      div_divisor;
  logic [QW_WEIGHT-1:0] div_quo;

  // Item decode
  assign in_i.ready = state_q == ST_IDLE;
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign is_push   = in_i.command == CMD_PUSH;
  assign full      = depth_q == DW'(STACK_DEPTH);
  assign trunc_bad = CW'(in_i.new_depth) > CW'(depth_q);
  assign push_ok   = is_push & !full;
  assign item_err  = is_push ? full : trunc_bad;
  assign val_sat   = (in_i.value > FULL_SCALE) ? FULL_SCALE : in_i.value;
  assign val_eff   = (val_sat < SMALL_LIMIT) ? '0 : val_sat;

  always_comb begin
    if (push_ok) begin
      tgt = depth_q + DW'(1);
    end else if (is_push || trunc_bad) begin
      tgt = depth_q;
    end else begin
      tgt = DW'(in_i.new_depth);
    end
  end

  // Prefix sums of depth k live at entry k-1
  assign rd_depth   = push_ok ? depth_q : tgt;
  assign raddr_full = rd_depth - DW'(1);
  assign raddr      = raddr_full[AW-1:0];
  assign depth_ext  = CW'(depth_q);

  // Shared 32x32 multiplier: weight recurrence partials, or weight times value
  always_comb begin
    if (state_q == ST_BMUL) begin
      mul_a = mcnt_q[1] ? 32'(q_q[59:32]) : q_q[31:0];
      mul_b = mcnt_q[0] ? 32'(EXP_M100[59:32]) : EXP_M100[31:0];
    end else begin
      mul_a = w_rd_q;
      mul_b = 32'(a_q);
    end
  end

  assign pidx = mcnt_q - 3'd1;

  always_comb begin
    case (pidx)
      3'd0:       part = ACC_W'(prod_q);
      3'd1, 3'd2: part = ACC_W'(prod_q) << 32;
      default:    part = ACC_W'(prod_q) << 64;
    endcase
  end

  assign f_sum = (prev_zero_q ? '0 : fp_rd_q) + FW'(w_rd_q);
  assign g_sum = (prev_zero_q ? '0 : gp_rd_q) + GW'(prod_q[PW-1:0]);

  assign mean_clamp = (div_quo > 32'(FULL_SCALE)) ? FULL_SCALE : div_quo[VALUE_W-1:0];
  assign mean_res   = (mean_clamp < SMALL_LIMIT) ? '0 : mean_clamp;

  // Divider operands: weight w = s*2^32 / (2^32 + s), or rounded mean (2G+F)/(2F)
  assign div_req.start = (state_q == ST_BDIV) || (state_q == ST_DIV && f_q != '0);
  assign div_req.wide  = state_q == ST_BDIV;
  assign div_dividend  = (state_q == ST_BDIV) ? DVW'({q_q[59:28], 32'h0})
                                              : DVW'({g_q, 1'b0}) + DVW'(f_q);
  assign div_divisor   = (state_q == ST_BDIV) ? DSW'({1'b1, q_q[59:28]})
                                              : DSW'({f_q, 1'b0});

  was_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Weight table and prefix sum memories
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BWAIT && div_stat.done) begin
      wmem[bidx_q] <= div_quo;
    end
    if (state_q == ST_SUM) begin
      fmem[widx_q] <= f_sum;
      gmem[widx_q] <= g_sum;
    end
    if (in_fire) begin
      w_rd_q  <= wmem[depth_q[AW-1:0]];
      fp_rd_q <= fmem[raddr];
      gp_rd_q <= gmem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BDIV;
      depth_q     <= '0;
      bidx_q      <= '0;
      q_q         <= EXP_M10[59:0];
      acc_q       <= '0;
      mcnt_q      <= '0;
      a_q         <= '0;
      push_ok_q   <= 1'b0;
      err_q       <= 1'b0;
      empty_q     <= 1'b0;
      prev_zero_q <= 1'b0;
      widx_q      <= '0;
      f_q         <= '0;
      g_q         <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_depth_q <= '0;
      out_acc_q   <= '0;
      out_err_q   <= 1'b0;
    end else begin
      if (out_fire && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_BDIV: begin
          state_q <= ST_BWAIT;
        end
        ST_BWAIT: begin
          if (div_stat.done) begin
            acc_q   <= '0;
            mcnt_q  <= '0;
            state_q <= ST_BMUL;
          end
        end
        ST_BMUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q != 3'd0) begin
            acc_q <= acc_q + part;
          end
          if (mcnt_q == 3'd4) begin
            state_q <= ST_BNEXT;
          end
        end
        ST_BNEXT: begin
          q_q <= acc_q[119:60];
          if (bidx_q == AW'(STACK_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            bidx_q  <= bidx_q + AW'(1);
            state_q <= ST_BDIV;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            a_q         <= val_eff;
            push_ok_q   <= push_ok;
            err_q       <= item_err;
            empty_q     <= tgt == '0;
            prev_zero_q <= depth_q == '0;
            widx_q      <= depth_q[AW-1:0];
            depth_q     <= tgt;
            state_q     <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (empty_q) begin
            res_q   <= FULL_SCALE;
            state_q <= ST_DONE;
          end else if (push_ok_q) begin
            state_q <= ST_SUM;
          end else begin
            f_q     <= fp_rd_q;
            g_q     <= gp_rd_q;
            state_q <= ST_DIV;
          end
        end
        ST_SUM: begin
          f_q     <= f_sum;
          g_q     <= g_sum;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (f_q == '0) begin
            res_q   <= FULL_SCALE;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            res_q   <= mean_res;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_depth_q <= depth_ext[DEPTH_FW-1:0];
            out_acc_q   <= res_q;
            out_err_q   <= err_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.depth    = out_depth_q;
  assign out_o.accuracy = out_acc_q;
  assign out_o.error    = out_err_q;

  ap_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  ap_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  ap_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  ap_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && div_stat.done) |-> div_quo <= 32'(FULL_SCALE))
    else $error("mean quotient above full scale");

  ap_err_keeps_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && item_err) |=> depth_q == $past(depth_q))
    else $error("refused item changed the depth");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import was_pkg::*;

  localparam int unsigned STACK_N    = STACK_DEPTH_DEF;
  localparam int unsigned ITEM_GOAL  = 500;
  localparam int unsigned FILL_AT    = 150;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned QUIET_MAX  = 40000;
  localparam int unsigned TAIL_WAIT  = 40;
  localparam int unsigned MAX_PRINTS = 50;
  localparam logic [63:0] ONE_Q60    = 64'h1 << 60;

  typedef struct {
    cmd_e                cmd;
    logic [VALUE_W-1:0]  value;
    logic [DEPTH_FW-1:0] new_depth;
    bit                  drain;
  } stack_op_t;

  typedef struct {
    logic [DEPTH_FW-1:0] depth;
    logic [VALUE_W-1:0]  accuracy;
    logic                error;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #6 clk_i = ~clk_i;

  was_in_if  in_ch ();
  was_out_if out_ch ();

  weighted_accuracy_stack_unit #(
    .STACK_DEPTH (STACK_N)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  stack_op_t          op_queue[$];
  report_t            pending_reports[$];
  logic [31:0]        weight_rom[STACK_N];
  logic [VALUE_W-1:0] stack_mem[STACK_N];
  int unsigned        model_depth = 0;
  int unsigned        gen_depth;
  int unsigned        n_items;
  int unsigned        acc_count;
  int unsigned        res_count;
  int unsigned        err_count = 0;
  int unsigned        hold_left;
  bit                 hold_done;
  int unsigned        quiet_cycles = 0;

  // Q0.60 e^(-1/n) from the series terms up to the twentieth power, each divided with truncation
  function automatic logic [63:0] exp_neg_recip(logic [63:0] n);
    logic [63:0] term;
    logic [63:0] acc;
    term = ONE_Q60;
    acc  = ONE_Q60;
    for (int k = 1; k <= 20; k++) begin
      term = term / (n * k);
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] q60_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic void build_weight_rom();
    logic [63:0] step;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] w;
    step = exp_neg_recip(64'd100);
    q    = exp_neg_recip(64'd10);
    for (int i = 0; i < STACK_N; i++) begin
      s = q >> 28;
      w = (s << 32) / ((64'h1 << 32) + s);
      weight_rom[i] = w[31:0];
      q = q60_product(q, step);
    end
  endfunction

  // Apply one op to the stack copy and return the depth, weighted mean and refusal flag
  function automatic report_t apply_stack_op(cmd_e cmd, logic [VALUE_W-1:0] value,
                                             logic [DEPTH_FW-1:0] new_depth);
    report_t            r;
    logic [VALUE_W-1:0] v;
    logic [63:0]        wsum;
    logic [63:0]        vsum;
    logic [63:0]        a;
    logic [63:0]        m;
    r.error = 1'b0;
    if (cmd == CMD_PUSH) begin
      v = (value > FULL_SCALE) ? FULL_SCALE : value;
      if (model_depth >= STACK_N) begin
        r.error = 1'b1;
      end else begin
        stack_mem[model_depth] = v;
        model_depth++;
      end
    end else if (new_depth > model_depth) begin
      r.error = 1'b1;
    end else begin
      model_depth = new_depth;
    end
    wsum = 64'd0;
    vsum = 64'd0;
    for (int i = 0; i < model_depth; i++) begin
      a = (stack_mem[i] < SMALL_LIMIT) ? 64'd0 : 64'(stack_mem[i]);
      wsum = wsum + 64'(weight_rom[i]);
      vsum = vsum + 64'(weight_rom[i]) * a;
    end
    if (wsum == 64'd0) begin
      m = 64'(FULL_SCALE);
    end else begin
      m = (2 * vsum + wsum) / (2 * wsum);
      if (m > 64'(FULL_SCALE)) m = 64'(FULL_SCALE);
      if (m < 64'(SMALL_LIMIT)) m = 64'd0;
    end
    r.accuracy = m[VALUE_W-1:0];
    r.depth    = DEPTH_FW'(model_depth);
    return r;
  endfunction

  // Queue an op and track the depth it leaves behind for the generator
  function automatic void queue_op(cmd_e cmd, int unsigned value, int unsigned new_depth,
                                   bit drain);
    stack_op_t op;
    op.cmd       = cmd;
    op.value     = VALUE_W'(value);
    op.new_depth = DEPTH_FW'(new_depth);
    op.drain     = drain;
    op_queue = {op_queue, op};
    if (cmd == CMD_PUSH) begin
      if (gen_depth < STACK_N) gen_depth++;
    end else if (new_depth <= gen_depth) begin
      gen_depth = new_depth;
    end
  endfunction

  function automatic int unsigned random_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 65);
      1:       return 65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic void queue_random_op();
    int unsigned r;
    int unsigned k;
    bit          drain;
    r     = $urandom_range(0, 99);
    drain = ($urandom_range(0, 99) < 3);
    if (r < 65) begin
      queue_op(CMD_PUSH, random_value(), 0, drain);
    end else if (r < 90) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_op(CMD_TRUNC, $urandom_range(0, 131071), $urandom_range(0, gen_depth), drain);
      end else begin
        k = (gen_depth < 3) ? gen_depth : 3;
        queue_op(CMD_TRUNC, $urandom_range(0, 131071), gen_depth - $urandom_range(0, k), drain);
      end
    end else begin
      queue_op(CMD_TRUNC, $urandom_range(0, 131071), $urandom_range(gen_depth + 1, 511), drain);
    end
  endfunction

  // Fill to the top, push past it, truncate to the top and past it, then cut back down
  function automatic void queue_fill_run();
    bit first;
    first = 1'b1;
    while (gen_depth < STACK_N) begin
      queue_op(CMD_PUSH, random_value(), 0, first);
      first = 1'b0;
    end
    repeat (3) queue_op(CMD_PUSH, random_value(), 0, 1'b0);
    queue_op(CMD_TRUNC, 0, STACK_N, 1'b0);
    queue_op(CMD_TRUNC, 0, STACK_N + 1, 1'b0);
    queue_op(CMD_TRUNC, 0, $urandom_range(0, 40), 1'b0);
  endfunction

  function automatic int unsigned idle_phase();
    if (acc_count * 3 < n_items) return 0;
    if (acc_count * 3 < 2 * n_items) return 1;
    return 2;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (idle_phase())
      0:       return 13;
      1:       return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (idle_phase())
      0:       return 55;
      1:       return 13;
      default: return 0;
    endcase
  endfunction

  // Driver: predict on each input transfer, then offer the next op
  always @(posedge clk_i or negedge rst_ni) begin
    bit      took;
    bit      drained;
    report_t rep;
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.command   <= CMD_PUSH;
      in_ch.value     <= '0;
      in_ch.new_depth <= '0;
      acc_count       <= 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        rep = apply_stack_op(cmd_e'(in_ch.command), in_ch.value, in_ch.new_depth);
        pending_reports = {pending_reports, rep};
        acc_count <= acc_count + 1;
      end
      drained = ((acc_count + (took ? 1 : 0)) == res_count);
      if (!in_ch.valid || took) begin
        if (op_queue.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (op_queue[0].drain && !drained) begin
          in_ch.valid <= 1'b0;
        end else if ($urandom_range(0, 99) < send_idle_pct()) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid     <= 1'b1;
          in_ch.command   <= op_queue[0].cmd;
          in_ch.value     <= op_queue[0].value;
          in_ch.new_depth <= op_queue[0].new_depth;
          void'(op_queue.pop_front());
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    report_t exp_rep;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      res_count    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_count <= res_count + 1;
        if (pending_reports.size() == 0) begin
          err_count++;
          if (err_count <= MAX_PRINTS)
            $display("%0t: unexpected result depth %0d accuracy %0d error %0b", $time,
                     out_ch.depth, out_ch.accuracy, out_ch.error);
        end else begin
          exp_rep = pending_reports.pop_front();
          if (out_ch.depth !== exp_rep.depth) begin
            err_count++;
            if (err_count <= MAX_PRINTS)
              $display("%0t: depth expected %0d actual %0d", $time, exp_rep.depth,
                       out_ch.depth);
          end
          if (out_ch.accuracy !== exp_rep.accuracy) begin
            err_count++;
            if (err_count <= MAX_PRINTS)
              $display("%0t: accuracy expected %0d actual %0d", $time, exp_rep.accuracy,
                       out_ch.accuracy);
          end
          if (out_ch.error !== exp_rep.error) begin
            err_count++;
            if (err_count <= MAX_PRINTS)
              $display("%0t: error expected %0b actual %0b", $time, exp_rep.error,
                       out_ch.error);
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && acc_count * 3 >= 2 * n_items + 30) begin
        hold_left    <= HOLD_LEN;
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    gen_depth       = 0;
    build_weight_rom();

    // Empty stack, refused truncates, small values, saturation, legal truncates
    queue_op(CMD_TRUNC, 0, 0, 1'b0);
    queue_op(CMD_TRUNC, 131071, 1, 1'b0);
    queue_op(CMD_TRUNC, 0, 511, 1'b0);
    queue_op(CMD_PUSH, 0, 0, 1'b0);
    queue_op(CMD_PUSH, 65, 0, 1'b0);
    queue_op(CMD_PUSH, 66, 0, 1'b0);
    queue_op(CMD_PUSH, 65536, 0, 1'b0);
    queue_op(CMD_PUSH, 131071, 0, 1'b0);
    queue_op(CMD_PUSH, 65537, 0, 1'b0);
    queue_op(CMD_TRUNC, 0, 6, 1'b0);
    queue_op(CMD_TRUNC, 0, 2, 1'b0);
    queue_op(CMD_TRUNC, 0, 7, 1'b0);
    queue_op(CMD_PUSH, 17'h0AAAA, 0, 1'b0);
    queue_op(CMD_PUSH, 17'h15555, 0, 1'b0);
    queue_op(CMD_PUSH, 1, 0, 1'b0);
    queue_op(CMD_TRUNC, 0, 9'h155, 1'b0);
    queue_op(CMD_TRUNC, 0, 9'h0AA, 1'b0);
    queue_op(CMD_TRUNC, 0, 0, 1'b0);
    queue_op(CMD_PUSH, 1, 0, 1'b0);
    queue_op(CMD_PUSH, 65, 0, 1'b0);
    queue_op(CMD_TRUNC, 0, 0, 1'b0);

    while (op_queue.size() < ITEM_GOAL) begin
      if (op_queue.size() == FILL_AT) begin
        queue_fill_run();
      end else begin
        queue_random_op();
      end
    end
    n_items = op_queue.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (op_queue.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
